/* rtl/plc_pkg.sv */
// -----------------------------------------------------------------------------
// plc_pkg
// Shared types, codes and sizes of the pinned LRU slot cache.
// -----------------------------------------------------------------------------
`default_nettype none

package plc_pkg;

   localparam int Ways          = 5;
   localparam int WayBits       = 3;
   localparam int TypeTagBits   = 16;
   localparam int TagInBits     = 16;
   localparam int OffsetBits    = 32;
   localparam int SizeBits      = 16;
   localparam int EntrySizeBits = 4;
   localparam int AgeBits       = 32;
   localparam int PinBits       = 8;
   localparam int CsrIndexBits  = 2;

   localparam logic [PinBits-1:0]  PinMax           = {PinBits{1'b1}};
   localparam logic [SizeBits-1:0] DefaultStoreSize = 16'd8;

   localparam logic [CsrIndexBits-1:0] CsrCacheEnable = 2'd0;
   localparam logic [CsrIndexBits-1:0] CsrScanSound   = 2'd1;

   typedef enum logic [3:0] {
      ACT_READ       = 4'd0,
      ACT_READ_PIN   = 4'd1,
      ACT_STORE_NOTE = 4'd2,
      ACT_WRITE_THRU = 4'd3,
      ACT_CLOBBER    = 4'd4,
      ACT_UNPIN      = 4'd5,
      ACT_PIN_QUERY  = 4'd6,
      ACT_FLUSH      = 4'd7,
      ACT_CALL       = 4'd8
   } action_type;

   typedef enum logic [1:0] {
      STS_NONE       = 2'd0,
      STS_HIT        = 2'd1,
      STS_FILLED     = 2'd2,
      STS_ALL_PINNED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_DIRECT  = 2'd0,
      KIND_GLOBAL  = 2'd1,
      KIND_POINTER = 2'd2
   } addr_kind_type;

   typedef struct packed {
      logic [3:0]            action;
      logic [OffsetBits-1:0] slot_offset;
      logic [TagInBits-1:0]  type_tag;
      logic [SizeBits-1:0]   access_size;
      logic                  cacheable;
      logic                  escaped;
      logic [1:0]            addr_kind;
      logic [WayBits-1:0]    way_sel;
   } item_type;

   typedef struct packed {
      logic               load;
      logic               scan_en;
      logic               scan_first;
      logic [WayBits-1:0] scan_idx;
      logic               commit;
   } cmd_type;

   typedef struct packed {
      logic need_scan;
   } stat_type;

endpackage

`default_nettype wire

/* rtl/plc_ifs.sv */
// -----------------------------------------------------------------------------
// plc channel interfaces
// Request, response and register write channels with valid/ready handshake.
// -----------------------------------------------------------------------------
`default_nettype none

interface plc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [3:0]                           action;
   logic signed [plc_pkg::OffsetBits-1:0] slot_offset;
   logic [plc_pkg::TagInBits-1:0]        type_tag;
   logic [plc_pkg::SizeBits-1:0]         access_size;
   logic                                 cacheable;
   logic                                 escaped;
   logic [1:0]                           addr_kind;
   logic [plc_pkg::WayBits-1:0]          way_sel;

   modport source (output valid, action, slot_offset, type_tag, access_size,
                   cacheable, escaped, addr_kind, way_sel, input ready);
   modport sink   (input valid, action, slot_offset, type_tag, access_size,
                   cacheable, escaped, addr_kind, way_sel, output ready);
endinterface

interface plc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  status;
   logic [plc_pkg::WayBits-1:0] way_index;
   logic                        pinned;
   logic [plc_pkg::Ways-1:0]    used_mask;

   modport source (output valid, status, way_index, pinned, used_mask, input ready);
   modport sink   (input valid, status, way_index, pinned, used_mask, output ready);
endinterface

interface plc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [plc_pkg::CsrIndexBits-1:0] index;
   logic                             data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/plc_ctrl.sv */
// -----------------------------------------------------------------------------
// plc_ctrl
// Sequencer: accepts a transaction, steps the way scan, commits the update.
// -----------------------------------------------------------------------------
`default_nettype none

module plc_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire plc_pkg::stat_type stat,
   output plc_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   localparam logic [plc_pkg::WayBits-1:0] LastWay = plc_pkg::WayBits'(plc_pkg::Ways - 1);

   state_type                   state_ff, state_in;
   logic [plc_pkg::WayBits-1:0] scan_idx_ff, scan_idx_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        commit;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign commit    = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      scan_idx_in  = scan_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            scan_idx_in = '0;
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!stat.need_scan || scan_idx_ff == LastWay) begin
               state_in    = ST_COMMIT;
               scan_idx_in = '0;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_COMMIT: begin
            if (commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd            = '0;
      cmd.load       = req_valid && (state_ff == ST_IDLE);
      cmd.scan_en    = (state_ff == ST_SCAN);
      cmd.scan_first = (scan_idx_ff == '0);
      cmd.scan_idx   = scan_idx_ff;
      cmd.commit     = commit;
   end

endmodule

`default_nettype wire

/* rtl/plc_datapath.sv */
// -----------------------------------------------------------------------------
// plc_datapath
// Way table, hit/LRU scan, range invalidation, pin counts and response register.
// -----------------------------------------------------------------------------
`default_nettype none

module plc_datapath #(
   parameter int TYPE_TAG_BITS = plc_pkg::TypeTagBits
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire plc_pkg::cmd_type                    cmd,
   output plc_pkg::stat_type                        stat,
   input  wire plc_pkg::item_type                   item_in,
   input  wire logic                                csr_we,
   input  wire logic [plc_pkg::CsrIndexBits-1:0]    csr_index,
   input  wire logic                                csr_data,
   output logic [1:0]                               rsp_status,
   output logic [plc_pkg::WayBits-1:0]              rsp_way_index,
   output logic                                     rsp_pinned,
   output logic [plc_pkg::Ways-1:0]                 rsp_used_mask
);

   localparam int TagW = (TYPE_TAG_BITS < plc_pkg::TagInBits) ?
                         TYPE_TAG_BITS : plc_pkg::TagInBits;
   localparam int Ways = plc_pkg::Ways;
   localparam int WB   = plc_pkg::WayBits;

   // configuration
   logic cache_enable_ff, scan_sound_ff;

   // latched transaction
   plc_pkg::item_type item_ff;
   logic [TagW-1:0]   item_tag;

   // way table
   logic [Ways-1:0]                      valid_ff, valid_in;
   logic [Ways-1:0]                      surv_ff, surv_in;
   logic [plc_pkg::OffsetBits-1:0]       off_ff [Ways];
   logic [plc_pkg::OffsetBits-1:0]       off_in [Ways];
   logic [TagW-1:0]                      tag_ff [Ways];
   logic [TagW-1:0]                      tag_in [Ways];
   logic [plc_pkg::EntrySizeBits-1:0]    esize_ff [Ways];
   logic [plc_pkg::EntrySizeBits-1:0]    esize_in [Ways];
   logic [plc_pkg::AgeBits-1:0]          age_ff [Ways];
   logic [plc_pkg::AgeBits-1:0]          age_in [Ways];
   logic [plc_pkg::PinBits-1:0]          pin_ff [Ways];
   logic [plc_pkg::PinBits-1:0]          pin_in [Ways];

   logic [plc_pkg::AgeBits-1:0]          age_clock_ff, age_clock_in;
   logic                                 pend_valid_ff, pend_valid_in;
   logic [plc_pkg::OffsetBits-1:0]       pend_off_ff, pend_off_in;
   logic                                 pend_surv_ff, pend_surv_in;
   logic [Ways-1:0]                      used_ff, used_in;

   // scan results
   logic                        hit_found_ff, hit_found_in;
   logic [WB-1:0]               hit_idx_ff, hit_idx_in;
   logic                        free_found_ff, free_found_in;
   logic [WB-1:0]               free_idx_ff, free_idx_in;
   logic                        best_found_ff, best_found_in;
   logic [WB-1:0]               best_idx_ff, best_idx_in;
   logic [plc_pkg::AgeBits-1:0] best_age_ff, best_age_in;

   // response register
   logic [1:0]      rsp_status_ff, rsp_status_in;
   logic [WB-1:0]   rsp_way_ff, rsp_way_in;
   logic            rsp_pinned_ff, rsp_pinned_in;
   logic [Ways-1:0] rsp_used_ff;

   // decode of the latched transaction
   logic                        size_ok, kind_direct, kind_global, offset_ok;
   logic [plc_pkg::SizeBits-1:0] st_size;
   logic [Ways-1:0]             overlap, exact, pin_nz;
   logic                        pick_ok;
   logic [WB-1:0]               pick_idx;

   assign item_tag    = item_ff.type_tag[TagW-1:0];
   assign size_ok     = (item_ff.access_size == 16'd1) || (item_ff.access_size == 16'd2) ||
                        (item_ff.access_size == 16'd4) || (item_ff.access_size == 16'd8);
   assign kind_direct = (item_ff.addr_kind == plc_pkg::KIND_DIRECT);
   assign kind_global = (item_ff.addr_kind == plc_pkg::KIND_GLOBAL);
   assign offset_ok   = (item_ff.slot_offset == pend_off_ff);
   assign st_size     = (item_ff.access_size == '0) ? plc_pkg::DefaultStoreSize
                                                    : item_ff.access_size;
   assign pick_ok     = free_found_ff || best_found_ff;
   assign pick_idx    = free_found_ff ? free_idx_ff : best_idx_ff;

   assign stat.need_scan = (item_ff.action == plc_pkg::ACT_READ) ||
                           (item_ff.action == plc_pkg::ACT_READ_PIN) ||
                           (item_ff.action == plc_pkg::ACT_WRITE_THRU);

   // overlap and exact-match test per way
   always_comb begin
      logic signed [33:0] ent_lo, ent_hi, st_lo, st_hi;
      st_lo = $signed({{2{item_ff.slot_offset[31]}}, item_ff.slot_offset});
      st_hi = st_lo + $signed({18'b0, st_size});
      for (int j = 0; j < Ways; j++) begin
         ent_lo     = $signed({{2{off_ff[j][31]}}, off_ff[j]});
         ent_hi     = ent_lo + $signed({30'b0, esize_ff[j]});
         overlap[j] = valid_ff[j] && (ent_lo < st_hi) && (st_lo < ent_hi);
         exact[j]   = (ent_lo == st_lo) &&
                      ({{(plc_pkg::SizeBits-plc_pkg::EntrySizeBits){1'b0}}, esize_ff[j]}
                       == st_size);
         pin_nz[j]  = (pin_ff[j] != '0);
      end
   end

   // one way per cycle: first hit, first free unpinned, oldest unpinned
   always_comb begin
      logic          s_hit, s_unpinned, s_valid;
      logic [WB-1:0] sidx;
      sidx          = cmd.scan_idx;
      hit_found_in  = cmd.scan_first ? 1'b0 : hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = cmd.scan_first ? 1'b0 : free_found_ff;
      free_idx_in   = free_idx_ff;
      best_found_in = cmd.scan_first ? 1'b0 : best_found_ff;
      best_idx_in   = best_idx_ff;
      best_age_in   = best_age_ff;
      s_valid       = valid_ff[sidx];
      s_hit         = s_valid && (off_ff[sidx] == item_ff.slot_offset) &&
                      (tag_ff[sidx] == item_tag);
      s_unpinned    = (pin_ff[sidx] == '0);
      if (cmd.scan_en) begin
         if (s_hit && !hit_found_in) begin
            hit_found_in = 1'b1;
            hit_idx_in   = sidx;
         end
         if (s_unpinned && !s_valid && !free_found_in) begin
            free_found_in = 1'b1;
            free_idx_in   = sidx;
         end
         if (s_unpinned && s_valid && (!best_found_in || age_ff[sidx] < best_age_in)) begin
            best_found_in = 1'b1;
            best_idx_in   = sidx;
            best_age_in   = age_ff[sidx];
         end
      end else begin
         hit_found_in  = hit_found_ff;
         free_found_in = free_found_ff;
         best_found_in = best_found_ff;
      end
   end

   // commit of one transaction
   always_comb begin
      logic          fill_en, touch_en, pin_inc, drop_all, drop_range, remember;
      logic          fill_surv;
      logic [WB-1:0] tgt;
      fill_en    = 1'b0;
      touch_en   = 1'b0;
      pin_inc    = 1'b0;
      drop_all   = 1'b0;
      drop_range = 1'b0;
      remember   = 1'b0;
      fill_surv  = 1'b0;
      tgt        = pick_idx;

      valid_in      = valid_ff;
      surv_in       = surv_ff;
      off_in        = off_ff;
      tag_in        = tag_ff;
      esize_in      = esize_ff;
      age_in        = age_ff;
      pin_in        = pin_ff;
      age_clock_in  = age_clock_ff;
      pend_valid_in = pend_valid_ff;
      pend_off_in   = pend_off_ff;
      pend_surv_in  = pend_surv_ff;
      used_in       = used_ff;
      rsp_status_in = plc_pkg::STS_NONE;
      rsp_way_in    = '0;
      rsp_pinned_in = 1'b0;

      if (cmd.commit) begin
         unique case (item_ff.action)
            plc_pkg::ACT_READ, plc_pkg::ACT_READ_PIN: begin
               if (cache_enable_ff && item_ff.cacheable && size_ok) begin
                  if (hit_found_ff) begin
                     touch_en      = 1'b1;
                     tgt           = hit_idx_ff;
                     rsp_status_in = plc_pkg::STS_HIT;
                  end else if (pick_ok) begin
                     fill_en       = 1'b1;
                     fill_surv     = scan_sound_ff && !item_ff.escaped;
                     rsp_status_in = plc_pkg::STS_FILLED;
                  end else begin
                     rsp_status_in = plc_pkg::STS_ALL_PINNED;
                  end
                  pin_inc = (item_ff.action == plc_pkg::ACT_READ_PIN) &&
                            (hit_found_ff || pick_ok);
               end
            end
            plc_pkg::ACT_STORE_NOTE: begin
               pend_valid_in = 1'b0;
               if (cache_enable_ff && !kind_global) begin
                  drop_all   = !kind_direct;
                  drop_range = kind_direct;
                  remember   = 1'b1;
               end
            end
            plc_pkg::ACT_WRITE_THRU: begin
               pend_valid_in = 1'b0;
               if (cache_enable_ff && pend_valid_ff && kind_direct && offset_ok &&
                   item_ff.cacheable && size_ok) begin
                  if (pick_ok) begin
                     fill_en       = 1'b1;
                     fill_surv     = pend_surv_ff;
                     rsp_status_in = plc_pkg::STS_FILLED;
                  end else begin
                     rsp_status_in = plc_pkg::STS_ALL_PINNED;
                  end
               end
            end
            plc_pkg::ACT_CLOBBER: begin
               if (cache_enable_ff && (item_ff.access_size != '0) && !kind_global) begin
                  drop_all   = !kind_direct;
                  drop_range = kind_direct;
               end
            end
            plc_pkg::ACT_UNPIN: begin
               for (int j = 0; j < Ways; j++) begin
                  if (item_ff.way_sel == WB'(j) && pin_nz[j]) begin
                     pin_in[j] = pin_ff[j] - 1'b1;
                  end
               end
            end
            plc_pkg::ACT_PIN_QUERY: begin
               for (int j = 0; j < Ways; j++) begin
                  if (item_ff.way_sel == WB'(j)) begin
                     rsp_pinned_in = pin_nz[j];
                  end
               end
            end
            plc_pkg::ACT_FLUSH: begin
               drop_all = 1'b1;
            end
            plc_pkg::ACT_CALL: begin
               valid_in = valid_ff & surv_ff;
            end
            default: begin
            end
         endcase

         if (fill_en || touch_en) begin
            age_clock_in = age_clock_ff + 1'b1;
            rsp_way_in   = tgt;
         end

         for (int j = 0; j < Ways; j++) begin
            if (tgt == WB'(j)) begin
               if (fill_en) begin
                  valid_in[j] = 1'b1;
                  off_in[j]   = item_ff.slot_offset;
                  tag_in[j]   = item_tag;
                  esize_in[j] = item_ff.access_size[plc_pkg::EntrySizeBits-1:0];
                  surv_in[j]  = fill_surv;
                  used_in[j]  = 1'b1;
               end
               if (fill_en || touch_en) begin
                  age_in[j] = age_clock_in;
               end
               if (pin_inc && pin_ff[j] != plc_pkg::PinMax) begin
                  pin_in[j] = pin_ff[j] + 1'b1;
               end
            end
            if (drop_all) begin
               valid_in[j] = 1'b0;
            end
            // highest matching way wins the pending survive bit
            if (drop_range && overlap[j]) begin
               valid_in[j] = 1'b0;
               if (remember && exact[j]) begin
                  pend_valid_in = 1'b1;
                  pend_off_in   = item_ff.slot_offset;
                  pend_surv_in  = surv_ff[j];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cache_enable_ff <= 1'b1;
         scan_sound_ff   <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            plc_pkg::CsrCacheEnable: cache_enable_ff <= csr_data;
            plc_pkg::CsrScanSound:   scan_sound_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         pin_ff        <= '{default: '0};
         age_clock_ff  <= '0;
         pend_valid_ff <= 1'b0;
         used_ff       <= '0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         pin_ff        <= pin_in;
         age_clock_ff  <= age_clock_in;
         pend_valid_ff <= pend_valid_in;
         used_ff       <= used_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
         best_found_ff <= best_found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= item_in;
      end
      surv_ff     <= surv_in;
      off_ff      <= off_in;
      tag_ff      <= tag_in;
      esize_ff    <= esize_in;
      age_ff      <= age_in;
      pend_off_ff  <= pend_off_in;
      pend_surv_ff <= pend_surv_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      best_idx_ff <= best_idx_in;
      best_age_ff <= best_age_in;
      if (cmd.commit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_way_ff    <= rsp_way_in;
         rsp_pinned_ff <= rsp_pinned_in;
         rsp_used_ff   <= used_in;
      end
   end

   assign rsp_status    = rsp_status_ff;
   assign rsp_way_index = rsp_way_ff;
   assign rsp_pinned    = rsp_pinned_ff;
   assign rsp_used_mask = rsp_used_ff;

endmodule

`default_nettype wire

/* rtl/pinned_lru_slot_cache.sv */
// -----------------------------------------------------------------------------
// pinned_lru_slot_cache
// Five-way fully associative frame slot cache with LRU fill, pinning and
// range invalidation.
// -----------------------------------------------------------------------------
// One transaction is in work at a time. For read, read-and-pin and
// write-through the hit and LRU victim search steps through the way table
// one way per cycle; then the commit state writes the update into the table
// and the response register, waiting while a previous response is not yet
// taken. All other actions leave the scan state after its first way. A new
// request is taken in the cycle after the commit, even while the previous
// response still waits to be taken. Register writes are always ready and
// must be issued while the block is idle.
`default_nettype none

module pinned_lru_slot_cache #(
   parameter int TYPE_TAG_BITS = plc_pkg::TypeTagBits
) (
   input  wire logic  clock,
   input  wire logic  reset,
   plc_req_if.sink    req_if,
   plc_rsp_if.source  rsp_if,
   plc_csr_if.sink    csr_if
);

   plc_pkg::cmd_type  cmd;
   plc_pkg::stat_type stat;
   plc_pkg::item_type item;

   always_comb begin
      item             = '0;
      item.action      = req_if.action;
      item.slot_offset = req_if.slot_offset;
      item.type_tag    = req_if.type_tag;
      item.access_size = req_if.access_size;
      item.cacheable   = req_if.cacheable;
      item.escaped     = req_if.escaped;
      item.addr_kind   = req_if.addr_kind;
      item.way_sel     = req_if.way_sel;
   end

   assign csr_if.ready = 1'b1;

   plc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   plc_datapath #(
      .TYPE_TAG_BITS (TYPE_TAG_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .item_in       (item),
      .csr_we        (csr_if.valid),
      .csr_index     (csr_if.index),
      .csr_data      (csr_if.data),
      .rsp_status    (rsp_if.status),
      .rsp_way_index (rsp_if.way_index),
      .rsp_pinned    (rsp_if.pinned),
      .rsp_used_mask (rsp_if.used_mask)
   );

endmodule

`default_nettype wire

/* rtl/plc_checker.sv */
// -----------------------------------------------------------------------------
// plc_checker
// Port-level assertions for the pinned LRU slot cache, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none

module plc_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [1:0]                  rsp_status,
   input wire logic [plc_pkg::WayBits-1:0] rsp_way_index,
   input wire logic                        rsp_pinned,
   input wire logic [plc_pkg::Ways-1:0]    rsp_used_mask
);

   // busy after accepting a transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted back to back");

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) &&
         $stable(rsp_way_index) && $stable(rsp_pinned) && $stable(rsp_used_mask)))
      else $error("response dropped or changed while stalled");

   // hit or fill reports a real way
   a_way_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == plc_pkg::STS_HIT || rsp_status == plc_pkg::STS_FILLED))
         |-> (rsp_way_index < plc_pkg::WayBits'(plc_pkg::Ways)))
      else $error("way index out of range");

   // pin answer only on bookkeeping responses
   a_pinned_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pinned) |-> (rsp_status == plc_pkg::STS_NONE))
      else $error("pinned flag with lookup status");

endmodule

bind pinned_lru_slot_cache plc_checker u_plc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_status    (rsp_if.status),
   .rsp_way_index (rsp_if.way_index),
   .rsp_pinned    (rsp_if.pinned),
   .rsp_used_mask (rsp_if.used_mask)
);

`default_nettype wire
